// File: rtl/core/sensor_gain_to_register_codes_defines.svh
// Assertion macros shared by the sensor gain code converter RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SENSOR_GAIN_TO_REGISTER_CODES_DEFINES_SVH
`define SENSOR_GAIN_TO_REGISTER_CODES_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define SGRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define SGRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sgrc_pkg.sv
// Package for the sensor gain code converter: constants, stage tables,
// the divider step function and the stage enable struct. No dependencies.
`default_nettype none

package sgrc_pkg;

	localparam int ReqW        = 20;
	localparam int AgOne       = 256;
	localparam int DgOne       = 4096;
	localparam int StageCount  = 7;
	localparam int FineStepMax = 31;
	localparam int FineBase    = 32;
	localparam int DgIntMax    = 8;
	localparam int DgFracMin   = 128;
	localparam int DgFracMax   = 255;

	typedef logic [ReqW-1:0] req_t;
	typedef logic [2:0]      stage_idx_t;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} stage_en_t;

	function automatic logic [7:0] stage_code(input stage_idx_t idx);
		case (idx)
			3'd0:    return 8'h00;
			3'd1:    return 8'h01;
			3'd2:    return 8'h80;
			3'd3:    return 8'h81;
			3'd4:    return 8'h83;
			3'd5:    return 8'h87;
			3'd6:    return 8'h8f;
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [13:0] stage_base(input stage_idx_t idx);
		case (idx)
			3'd0:    return 14'd256;
			3'd1:    return 14'd512;
			3'd2:    return 14'd873;
			3'd3:    return 14'd1746;
			3'd4:    return 14'd3492;
			3'd5:    return 14'd6984;
			3'd6:    return 14'd13968;
			default: return 14'd256;
		endcase
	endfunction

	function automatic logic [8:0] stage_inc(input stage_idx_t idx);
		case (idx)
			3'd0:    return 9'd8;
			3'd1:    return 9'd16;
			3'd2:    return 9'd27;
			3'd3:    return 9'd55;
			3'd4:    return 9'd109;
			3'd5:    return 9'd218;
			3'd6:    return 9'd436;
			default: return 9'd8;
		endcase
	endfunction

	// one restoring-division step: {quotient bit, new remainder}
	function automatic logic [14:0] restore_step(input logic [13:0] rem,
			input logic [13:0] dvs);
		if (rem >= dvs) begin
			return {1'b1, rem - dvs};
		end
		return {1'b0, rem};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/sgrc_ctrl.sv
// Valid/enable chain of the four-stage converter pipeline.
// Depends on sgrc_pkg and the shared assertion macro header.
`default_nettype none
`include "sensor_gain_to_register_codes_defines.svh"

module sgrc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output sgrc_pkg::stage_en_t    en
);

	logic v_s1, v_s2, v_s3, v_s4;

	// a stage loads when empty or when its content moves on
	always_comb begin
		en.en4 = !v_s4 || out_ready;
		en.en3 = !v_s3 || en.en4;
		en.en2 = !v_s2 || en.en3;
		en.en1 = !v_s1 || en.en2;
	end

	assign in_ready  = en.en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.en1) begin
				v_s1 <= in_valid;
			end
			if (en.en2) begin
				v_s2 <= v_s1;
			end
			if (en.en3) begin
				v_s3 <= v_s2;
			end
			if (en.en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	`SGRC_ASSERT_NOW(a_blocked_only_when_full, !in_ready, v_s1 && v_s2 && v_s3 && v_s4, "input blocked with a bubble in the pipe")
	`SGRC_ASSERT_NEXT(a_accept_lands_s1, in_valid && in_ready, v_s1, "accepted transfer lost at stage 1")
	`SGRC_ASSERT_NEXT(a_stall_holds, v_s2 && !en.en2, v_s2 && v_s3 && v_s4, "stalled item dropped")
	`SGRC_ASSERT_NEXT(a_s3_moves_on, v_s3 && en.en4, v_s4, "stage 3 item not passed to output")

endmodule

`default_nettype wire

// File: rtl/core/sgrc_analog.sv
// Analog gain path: clamp, coarse stage select, five-bit rounded step
// divider over stages 2-3, achieved gain in stage 4. Depends on sgrc_pkg.
`default_nettype none

module sgrc_analog (
	input  wire logic                 clk,
	input  wire sgrc_pkg::stage_en_t  en,
	input  wire logic [19:0]          analog_gain_request,
	output logic [7:0]                analog_coarse_code,
	output logic [5:0]                analog_fine_code,
	output logic [14:0]               analog_gain_achieved
);

	// stage 1: clamp and pick stage
	sgrc_pkg::req_t       ag;
	sgrc_pkg::stage_idx_t idx;
	sgrc_pkg::req_t       num;
	sgrc_pkg::stage_idx_t idx_s1;
	sgrc_pkg::req_t       num_s1;

	always_comb begin
		ag = (analog_gain_request < sgrc_pkg::req_t'(sgrc_pkg::AgOne))
			? sgrc_pkg::req_t'(sgrc_pkg::AgOne) : analog_gain_request;
		idx = '0;
		for (int k = 1; k < sgrc_pkg::StageCount; k++) begin
			if (ag >= sgrc_pkg::req_t'(sgrc_pkg::stage_base(sgrc_pkg::stage_idx_t'(k)))) begin
				idx = sgrc_pkg::stage_idx_t'(k);
			end
		end
		// offset into stage plus half a step for rounding
		num = ag - sgrc_pkg::req_t'(sgrc_pkg::stage_base(idx))
			+ sgrc_pkg::req_t'(sgrc_pkg::stage_inc(idx) >> 1);
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			idx_s1 <= idx;
			num_s1 <= num;
		end
	end

	// stage 2: saturation check, quotient bits 4..2
	logic [8:0]           inc2;
	logic                 sat;
	logic [14:0]          st4, st3, st2;
	sgrc_pkg::stage_idx_t idx_s2;
	logic                 sat_s2;
	logic [2:0]           qh_s2;
	logic [10:0]          rem_s2;

	always_comb begin
		inc2 = sgrc_pkg::stage_inc(idx_s1);
		sat  = num_s1 >= {6'b0, inc2, 5'b0};
		st4  = sgrc_pkg::restore_step(num_s1[13:0], {1'b0, inc2, 4'b0});
		st3  = sgrc_pkg::restore_step(st4[13:0], {2'b0, inc2, 3'b0});
		st2  = sgrc_pkg::restore_step(st3[13:0], {3'b0, inc2, 2'b0});
	end

	always_ff @(posedge clk) begin
		if (en.en2) begin
			idx_s2 <= idx_s1;
			sat_s2 <= sat;
			qh_s2  <= {st4[14], st3[14], st2[14]};
			rem_s2 <= st2[10:0];
		end
	end

	// stage 3: quotient bits 1..0 and cap
	logic [8:0]           inc3;
	logic [14:0]          st1, st0;
	logic [4:0]           step;
	sgrc_pkg::stage_idx_t idx_s3;
	logic [4:0]           step_s3;

	always_comb begin
		inc3 = sgrc_pkg::stage_inc(idx_s2);
		st1  = sgrc_pkg::restore_step({3'b0, rem_s2}, {4'b0, inc3, 1'b0});
		st0  = sgrc_pkg::restore_step(st1[13:0], {5'b0, inc3});
		step = sat_s2 ? 5'(sgrc_pkg::FineStepMax) : {qh_s2, st1[14], st0[14]};
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			idx_s3  <= idx_s2;
			step_s3 <= step;
		end
	end

	// stage 4: codes and achieved gain
	logic [13:0] prod;
	logic [7:0]  coarse_s4;
	logic [5:0]  fine_s4;
	logic [14:0] gain_s4;

	always_comb begin
		prod = 14'(step_s3) * 14'(sgrc_pkg::stage_inc(idx_s3));
	end

	always_ff @(posedge clk) begin
		if (en.en4) begin
			coarse_s4 <= sgrc_pkg::stage_code(idx_s3);
			fine_s4   <= 6'(sgrc_pkg::FineBase) + {1'b0, step_s3};
			gain_s4   <= 15'(sgrc_pkg::stage_base(idx_s3)) + {1'b0, prod};
		end
	end

	assign analog_coarse_code   = coarse_s4;
	assign analog_fine_code     = fine_s4;
	assign analog_gain_achieved = gain_s4;

endmodule

`default_nettype wire

// File: rtl/core/sgrc_digital.sv
// Digital gain path: clamp, integer split, rounded fraction by a seven-bit
// divider over stages 2-3, achieved gain in stage 4. Depends on sgrc_pkg.
`default_nettype none

module sgrc_digital (
	input  wire logic                 clk,
	input  wire sgrc_pkg::stage_en_t  en,
	input  wire logic [19:0]          digital_gain_request,
	output logic [2:0]                digital_integer_code,
	output logic [7:0]                digital_fine_code,
	output logic [15:0]               digital_gain_achieved
);

	// stage 1: clamp, integer part, rounded dividend (dg + 16*ip) / 32
	sgrc_pkg::req_t dg;
	logic [7:0]     ip_raw;
	logic [3:0]     ip;
	logic [20:0]    m;
	logic [3:0]     ip_s1;
	logic [15:0]    q_s1;

	always_comb begin
		dg = (digital_gain_request < sgrc_pkg::req_t'(sgrc_pkg::DgOne))
			? sgrc_pkg::req_t'(sgrc_pkg::DgOne) : digital_gain_request;
		ip_raw = dg[19:12];
		ip = (ip_raw > 8'(sgrc_pkg::DgIntMax)) ? 4'(sgrc_pkg::DgIntMax) : ip_raw[3:0];
		m  = {1'b0, dg} + {13'b0, ip, 4'b0};
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			ip_s1 <= ip;
			q_s1  <= m[20:5];
		end
	end

	// stage 2: clamp checks, quotient bits 6..4 of (q - 128*ip) / ip
	logic        sat_hi, sat_lo;
	logic [15:0] diff;
	logic [14:0] st6, st5, st4;
	logic [3:0]  ip_s2;
	logic        sat_hi_s2, sat_lo_s2;
	logic [2:0]  qh_s2;
	logic [6:0]  rem_s2;

	always_comb begin
		sat_hi = q_s1 >= {4'b0, ip_s1, 8'b0};
		sat_lo = q_s1 <  {5'b0, ip_s1, 7'b0};
		diff   = q_s1 - {5'b0, ip_s1, 7'b0};
		st6    = sgrc_pkg::restore_step(diff[13:0], {4'b0, ip_s1, 6'b0});
		st5    = sgrc_pkg::restore_step(st6[13:0], {5'b0, ip_s1, 5'b0});
		st4    = sgrc_pkg::restore_step(st5[13:0], {6'b0, ip_s1, 4'b0});
	end

	always_ff @(posedge clk) begin
		if (en.en2) begin
			ip_s2     <= ip_s1;
			sat_hi_s2 <= sat_hi;
			sat_lo_s2 <= sat_lo;
			qh_s2     <= {st6[14], st5[14], st4[14]};
			rem_s2    <= st4[6:0];
		end
	end

	// stage 3: quotient bits 3..0 and clamp to 128..255
	logic [14:0] st3, st2, st1, st0;
	logic [7:0]  frac;
	logic [3:0]  ip_s3;
	logic [7:0]  frac_s3;

	always_comb begin
		st3 = sgrc_pkg::restore_step({7'b0, rem_s2}, {7'b0, ip_s2, 3'b0});
		st2 = sgrc_pkg::restore_step(st3[13:0], {8'b0, ip_s2, 2'b0});
		st1 = sgrc_pkg::restore_step(st2[13:0], {9'b0, ip_s2, 1'b0});
		st0 = sgrc_pkg::restore_step(st1[13:0], {10'b0, ip_s2});
		if (sat_hi_s2) begin
			frac = 8'(sgrc_pkg::DgFracMax);
		end else if (sat_lo_s2) begin
			frac = 8'(sgrc_pkg::DgFracMin);
		end else begin
			frac = {1'b1, qh_s2, st3[14], st2[14], st1[14], st0[14]};
		end
	end

	always_ff @(posedge clk) begin
		if (en.en3) begin
			ip_s3   <= ip_s2;
			frac_s3 <= frac;
		end
	end

	// stage 4: codes and achieved gain ip * frac * 32
	logic [11:0] prod;
	logic [2:0]  int_s4;
	logic [7:0]  fine_s4;
	logic [15:0] gain_s4;

	always_comb begin
		prod = 12'(ip_s3) * 12'(frac_s3);
	end

	always_ff @(posedge clk) begin
		if (en.en4) begin
			int_s4  <= 3'(ip_s3 - 4'd1);
			fine_s4 <= frac_s3;
			gain_s4 <= {prod[10:0], 5'b0};
		end
	end

	assign digital_integer_code  = int_s4;
	assign digital_fine_code     = fine_s4;
	assign digital_gain_achieved = gain_s4;

endmodule

`default_nettype wire

// File: rtl/core/sensor_gain_to_register_codes.sv
// Top level of the sensor gain to register code converter.
// Depends on sgrc_pkg, sgrc_ctrl, sgrc_analog and sgrc_digital.
//
// Converts a requested analog gain (Q8, 256 = 1x) and digital gain (Q12,
// 4096 = 1x) into sensor register codes plus the gains those codes really
// apply. Each input transfer yields exactly one output transfer, in order.
// The block is a four-stage pipeline: a new transfer is taken every
// cycle as long as the output side keeps taking results, and each
// result is held on the outputs by the stage 4 registers until it is
// taken. When the output stalls, the stages
// fill up behind it and in_ready drops only once all four hold an item.
// Stage 1 clamps both requests to 1x, selects the analog coarse stage from
// seven fixed bases and forms the rounded dividends; stages 2 and 3 run the
// restoring dividers (analog fine step, capped at 31; digital fraction,
// clamped to 128..255) a few bits per stage; stage 4 forms the codes and the
// achieved gains with one small multiply per path and is the output
// register. The block has no configuration and no state beyond the
// pipeline; reset only clears the valid bits.
`default_nettype none

module sensor_gain_to_register_codes (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [19:0] analog_gain_request,
	input  wire logic [19:0] digital_gain_request,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       analog_coarse_code,
	output logic [5:0]       analog_fine_code,
	output logic [14:0]      analog_gain_achieved,
	output logic [2:0]       digital_integer_code,
	output logic [7:0]       digital_fine_code,
	output logic [15:0]      digital_gain_achieved
);

	// shared load enables, one per stage
	sgrc_pkg::stage_en_t en;

	sgrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.en        (en)
	);

	// analog path: coarse stage and rounded fine step
	sgrc_analog u_analog (
		.clk                  (clk),
		.en                   (en),
		.analog_gain_request  (analog_gain_request),
		.analog_coarse_code   (analog_coarse_code),
		.analog_fine_code     (analog_fine_code),
		.analog_gain_achieved (analog_gain_achieved)
	);

	// digital path: integer multiplier and 1/128 fraction
	sgrc_digital u_digital (
		.clk                   (clk),
		.en                    (en),
		.digital_gain_request  (digital_gain_request),
		.digital_integer_code  (digital_integer_code),
		.digital_fine_code     (digital_fine_code),
		.digital_gain_achieved (digital_gain_achieved)
	);

endmodule

`default_nettype wire

// File: tb/sensor_gain_to_register_codes_test.sv
// Self-checking bench for the sensor gain to register code converter.
// Uses sgrc_pkg for request types and gain constants; needs only the RTL.
// Directed table first, then constrained-by-hand random requests, both scored.
module sensor_gain_to_register_codes_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RandomCount = 1300;
	localparam int          CycleLimit  = 200000;
	localparam int          DrainCycles = 16;
	localparam int          IdlePct     = 31;
	localparam int unsigned FracUnits   = 128;

	// coarse stage tables: code, base (Q8), fine increment (Q8)
	localparam logic [7:0]  STAGE_CODE [sgrc_pkg::StageCount] = '{8'h00, 8'h01, 8'h80,
		8'h81, 8'h83, 8'h87, 8'h8f};
	localparam int unsigned STAGE_BASE [sgrc_pkg::StageCount] = '{256, 512, 873, 1746,
		3492, 6984, 13968};
	localparam int unsigned STAGE_INC  [sgrc_pkg::StageCount] = '{8, 16, 27, 55, 109,
		218, 436};

	// one result transfer, field for field
	typedef struct packed {
		logic [7:0]  coarse;
		logic [5:0]  fine;
		logic [14:0] analog_achieved;
		logic [2:0]  int_code;
		logic [7:0]  digital_fine;
		logic [15:0] digital_achieved;
	} gain_codes_t;

	typedef struct {
		sgrc_pkg::req_t analog;
		sgrc_pkg::req_t digital;
		bit             typed;
		gain_codes_t    codes;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] analog_gain_request;
	logic [19:0] digital_gain_request;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  analog_coarse_code;
	logic [5:0]  analog_fine_code;
	logic [14:0] analog_gain_achieved;
	logic [2:0]  digital_integer_code;
	logic [7:0]  digital_fine_code;
	logic [15:0] digital_gain_achieved;

	gain_codes_t  codes_on_bus;      // expectation for the request currently driven
	gain_codes_t  codes_awaited_q[$]; // expectations in transfer order
	gain_codes_t  oldest_codes;
	request_row_t directed_rows[$];
	bit           steady;            // no idling on either side while set
	int           failures;
	int           cycle_count;

	sensor_gain_to_register_codes dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.analog_gain_request  (analog_gain_request),
		.digital_gain_request (digital_gain_request),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.analog_coarse_code   (analog_coarse_code),
		.analog_fine_code     (analog_fine_code),
		.analog_gain_achieved (analog_gain_achieved),
		.digital_integer_code (digital_integer_code),
		.digital_fine_code    (digital_fine_code),
		.digital_gain_achieved(digital_gain_achieved)
	);

	// Expected codes for one request pair.
	// Analog: clamp to 1x, take the highest stage whose base fits, round the
	// fine step and cap it. Digital: clamp to 1x, cap the integer part at 8,
	// round the 1/128 fraction of that integer and clamp it to 128..255.
	function automatic gain_codes_t convert_gain(input sgrc_pkg::req_t analog_req,
			input sgrc_pkg::req_t digital_req);
		int unsigned analog, digital, stage, step, whole, frac;
		int          s;
		gain_codes_t codes;
		analog = (analog_req < sgrc_pkg::AgOne) ? sgrc_pkg::AgOne : analog_req;
		stage = 0;
		for (s = 1; s < sgrc_pkg::StageCount; s++) begin
			if (analog >= STAGE_BASE[s]) begin
				stage = s;
			end
		end
		step = (analog - STAGE_BASE[stage] + STAGE_INC[stage] / 2) / STAGE_INC[stage];
		if (step > sgrc_pkg::FineStepMax) begin
			step = sgrc_pkg::FineStepMax;
		end

		digital = (digital_req < sgrc_pkg::DgOne) ? sgrc_pkg::DgOne : digital_req;
		whole = digital / sgrc_pkg::DgOne;
		if (whole > sgrc_pkg::DgIntMax) begin
			whole = sgrc_pkg::DgIntMax;
		end
		frac = (digital * FracUnits + (whole * sgrc_pkg::DgOne) / 2)
			/ (whole * sgrc_pkg::DgOne);
		if (frac < sgrc_pkg::DgFracMin) begin
			frac = sgrc_pkg::DgFracMin;
		end
		if (frac > sgrc_pkg::DgFracMax) begin
			frac = sgrc_pkg::DgFracMax;
		end

		codes.coarse           = STAGE_CODE[stage];
		codes.fine             = 6'(sgrc_pkg::FineBase + step);
		codes.analog_achieved  = 15'(STAGE_BASE[stage] + step * STAGE_INC[stage]);
		codes.int_code         = 3'(whole - 1);
		codes.digital_fine     = 8'(frac);
		codes.digital_achieved = 16'((whole * frac * sgrc_pkg::DgOne) / FracUnits);
		return codes;
	endfunction

	task automatic add_row(input sgrc_pkg::req_t analog, input sgrc_pkg::req_t digital,
			input bit typed, input gain_codes_t codes);
		request_row_t row;
		row.analog  = analog;
		row.digital = digital;
		row.typed   = typed;
		row.codes   = codes;
		directed_rows.push_back(row);
	endtask

	// Drive one request starting at a falling edge; returns at the falling
	// edge after its transfer. Valid stays up from the first cycle it is raised.
	task automatic send_request(input sgrc_pkg::req_t analog,
			input sgrc_pkg::req_t digital, input gain_codes_t codes);
		while (!steady && $urandom_range(99) < IdlePct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid             = 1'b1;
		analog_gain_request  = analog;
		digital_gain_request = digital;
		codes_on_bus         = codes;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Random analog request: the useful range most often, some near stage
	// boundaries, the rest anywhere in the 20-bit field.
	function automatic sgrc_pkg::req_t random_analog();
		int unsigned kind, s;
		kind = $urandom_range(99);
		s    = $urandom_range(sgrc_pkg::StageCount - 1);
		if (kind < 40) begin
			return sgrc_pkg::req_t'($urandom_range(30000));
		end else if (kind < 65) begin
			return sgrc_pkg::req_t'(STAGE_BASE[s] - STAGE_INC[s]
				+ $urandom_range(2 * STAGE_INC[s]));
		end
		return sgrc_pkg::req_t'($urandom);
	endfunction

	// Random digital request: same idea, boundaries at integer multiples of 1x.
	function automatic sgrc_pkg::req_t random_digital();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 40) begin
			return sgrc_pkg::req_t'($urandom_range(40000));
		end else if (kind < 65) begin
			return sgrc_pkg::req_t'($urandom_range(9, 1) * sgrc_pkg::DgOne - 64
				+ $urandom_range(128));
		end
		return sgrc_pkg::req_t'($urandom);
	endfunction

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// Output side back-pressure; held off entirely during the steady stretch.
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IdlePct);
	end

	// Scoreboard. Input transfers queue their expectation; output transfers
	// are scored against the oldest one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				codes_awaited_q.push_back(codes_on_bus);
			end
			if (out_valid && out_ready) begin
				if (codes_awaited_q.size() == 0) begin
					$error("result transfer with no request outstanding");
					failures++;
				end else begin
					oldest_codes = codes_awaited_q.pop_front();
					if (analog_coarse_code !== oldest_codes.coarse) begin
						$error("analog_coarse_code: expected %0d, actual %0d",
							oldest_codes.coarse, analog_coarse_code);
						failures++;
					end
					if (analog_fine_code !== oldest_codes.fine) begin
						$error("analog_fine_code: expected %0d, actual %0d",
							oldest_codes.fine, analog_fine_code);
						failures++;
					end
					if (analog_gain_achieved !== oldest_codes.analog_achieved) begin
						$error("analog_gain_achieved: expected %0d, actual %0d",
							oldest_codes.analog_achieved, analog_gain_achieved);
						failures++;
					end
					if (digital_integer_code !== oldest_codes.int_code) begin
						$error("digital_integer_code: expected %0d, actual %0d",
							oldest_codes.int_code, digital_integer_code);
						failures++;
					end
					if (digital_fine_code !== oldest_codes.digital_fine) begin
						$error("digital_fine_code: expected %0d, actual %0d",
							oldest_codes.digital_fine, digital_fine_code);
						failures++;
					end
					if (digital_gain_achieved !== oldest_codes.digital_achieved) begin
						$error("digital_gain_achieved: expected %0d, actual %0d",
							oldest_codes.digital_achieved, digital_gain_achieved);
						failures++;
					end
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n               = 1'b0;
		in_valid             = 1'b0;
		analog_gain_request  = '0;
		digital_gain_request = '0;
		codes_on_bus         = '0;
		steady               = 1'b0;
		failures             = 0;
		cycle_count          = 0;

		// Directed rows. Expected codes are typed in only for the floor,
		// the ceiling and the fraction overflow; the rest go through the
		// predictor.
		// below 1x on both paths, and exactly 1x
		add_row(20'd0, 20'd0, 1'b1, '{8'h00, 6'h20, 15'd256, 3'd0, 8'd128, 16'd4096});
		add_row(20'd255, 20'd4095, 1'b1,
			'{8'h00, 6'h20, 15'd256, 3'd0, 8'd128, 16'd4096});
		add_row(20'd256, 20'd4096, 1'b1,
			'{8'h00, 6'h20, 15'd256, 3'd0, 8'd128, 16'd4096});
		// all ones: top stage with capped step, integer capped, fraction clamped
		add_row(20'hFFFFF, 20'hFFFFF, 1'b1,
			'{8'h8f, 6'h3f, 15'd27484, 3'd7, 8'd255, 16'd65280});
		// just below a half step; digital fraction rounds past 255
		add_row(20'd259, 20'd8191, 1'b1,
			'{8'h00, 6'h20, 15'd256, 3'd0, 8'd255, 16'd8160});
		// half step rounds up; stage edges on either side of each base
		add_row(20'd260, 20'd8192, 1'b0, '0);
		add_row(20'd511, 20'd12288, 1'b0, '0);
		add_row(20'd512, 20'd32767, 1'b0, '0);
		add_row(20'd872, 20'd32768, 1'b0, '0);
		add_row(20'd873, 20'd36863, 1'b0, '0);
		add_row(20'd1745, 20'd36864, 1'b0, '0);
		add_row(20'd1746, 20'd6144, 1'b0, '0);
		add_row(20'd3491, 20'd4097, 1'b0, '0);
		add_row(20'd3492, 20'd20480, 1'b0, '0);
		add_row(20'd6983, 20'd28672, 1'b0, '0);
		add_row(20'd6984, 20'd65535, 1'b0, '0);
		add_row(20'd13967, 20'd65536, 1'b0, '0);
		add_row(20'd13968, 20'd14336, 1'b0, '0);
		// top of the fine range, the value just above it and the first that saturates it
		add_row(20'd27484, 20'd12000, 1'b0, '0);
		add_row(20'd27485, 20'd50000, 1'b0, '0);
		add_row(20'd27702, 20'd40960, 1'b0, '0);
		add_row(20'd1000, 20'd14336, 1'b0, '0);
		add_row(20'h80000, 20'h80000, 1'b0, '0);

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].analog, directed_rows[i].digital,
				directed_rows[i].typed ? directed_rows[i].codes :
				convert_gain(directed_rows[i].analog, directed_rows[i].digital));
		end

		// Random requests; a stretch in the middle runs back to back with
		// the output always ready so the pipeline streams at full rate.
		for (int n = 0; n < RandomCount; n++) begin
			sgrc_pkg::req_t analog, digital;
			steady  = (n >= 400) && (n < 700);
			analog  = random_analog();
			digital = random_digital();
			send_request(analog, digital, convert_gain(analog, digital));
		end
		in_valid = 1'b0;
		steady   = 1'b0;

		// drain, then give any stray result time to show up
		while (codes_awaited_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);

		if (failures == 0 && codes_awaited_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: sensor_gain_to_register_codes.f
+incdir+rtl/core
rtl/core/sgrc_pkg.sv
rtl/core/sgrc_ctrl.sv
rtl/core/sgrc_analog.sv
rtl/core/sgrc_digital.sv
rtl/core/sensor_gain_to_register_codes.sv
tb/sensor_gain_to_register_codes_test.sv
